// ===== sv/mpwm_pkg.sv =====
// shared constants, codes and control types of the multichannel pwm scheduler
package mpwm_pkg;

    // field widths
    localparam int CMD_W     = 2;
    localparam int PIN_W     = 5;
    localparam int LOAD_W    = 23;
    localparam int MIN_W     = 22;
    localparam int STAT_W    = 2;
    localparam int IN_DATA_W = 80;
    localparam int CFG_IDX_W = 1;

    // default channel count
    localparam int DEF_NUM_PINS = 17;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_PERIOD = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_ACTIVE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LOAD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOAD = 1'd1;

    // configuration reset values
    localparam logic [MIN_W-1:0]  RST_MIN_LOAD = 22'd500;
    localparam logic [LOAD_W-1:0] RST_MAX_LOAD = 23'd8000000;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic set_check;
        logic set_clamp;
        logic set_low;
        logic set_commit;
        logic remove;
        logic tick_step;
        logic out_load;
    } t_ctl;

    // status from datapath to controller
    typedef struct packed {
        logic is_tick;
        logic is_set;
        logic is_remove;
        logic idx_last;
        logic out_free;
    } t_stat;

endpackage

// ===== sv/mpwm_ctrl.sv =====
// sequencing state machine of the multichannel pwm scheduler
module mpwm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  mpwm_pkg::t_stat i_stat,
    output mpwm_pkg::t_ctl  o_ctl
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_SET1   = 4'd2;
    localparam logic [3:0] S_SET2   = 4'd3;
    localparam logic [3:0] S_SET3   = 4'd4;
    localparam logic [3:0] S_SET4   = 4'd5;
    localparam logic [3:0] S_REMOVE = 4'd6;
    localparam logic [3:0] S_TICK   = 4'd7;
    localparam logic [3:0] S_DRAIN  = 4'd8;
    localparam logic [3:0] S_FINISH = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_s_tready = (r_state == S_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_ctl.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_tick) begin
                    n_state = S_TICK;
                end else if (i_stat.is_set) begin
                    n_state = S_SET1;
                end else if (i_stat.is_remove) begin
                    n_state = S_REMOVE;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SET1: begin
                o_ctl.set_check = 1'b1;
                n_state         = S_SET2;
            end
            S_SET2: begin
                o_ctl.set_clamp = 1'b1;
                n_state         = S_SET3;
            end
            S_SET3: begin
                o_ctl.set_low = 1'b1;
                n_state       = S_SET4;
            end
            S_SET4: begin
                o_ctl.set_commit = 1'b1;
                n_state          = S_FINISH;
            end
            S_REMOVE: begin
                o_ctl.remove = 1'b1;
                n_state      = S_FINISH;
            end
            S_TICK: begin
                o_ctl.tick_step = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/mpwm_dpath.sv =====
// channel store, clamp and tick arithmetic and result register of the pwm scheduler
module mpwm_dpath #(
    parameter int NUM_PINS = mpwm_pkg::DEF_NUM_PINS,
    parameter int OUT_W    = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mpwm_pkg::t_ctl                    i_ctl,
    output mpwm_pkg::t_stat                   o_stat,
    input  logic [mpwm_pkg::CMD_W-1:0]        i_command,
    input  logic [mpwm_pkg::IN_DATA_W-1:0]    i_data,
    input  logic                              i_cfg_we,
    input  logic [mpwm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mpwm_pkg::LOAD_W-1:0]       i_cfg_data,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [OUT_W-1:0]                  o_m_tdata
);

    localparam int LW    = mpwm_pkg::LOAD_W;
    localparam int MW    = mpwm_pkg::MIN_W;
    localparam int PW    = mpwm_pkg::PIN_W;
    localparam int IDX_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
    localparam int USED  = 2 * NUM_PINS + LW + 2 + mpwm_pkg::STAT_W;
    localparam logic [PW:0]      NUM_PINS_V = (PW + 1)'(NUM_PINS);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NUM_PINS - 1);

    // captured word
    logic [mpwm_pkg::CMD_W-1:0] r_cmd;
    logic [PW-1:0]              r_pin;
    logic [LW-1:0]              r_period;
    logic [LW-1:0]              r_req;
    logic                       r_level;
    logic [LW-1:0]              r_elapsed;

    // configuration
    logic [MW-1:0] r_min_load;
    logic [LW-1:0] r_max_load;

    // channel store
    logic [NUM_PINS-1:0] r_active;
    logic [NUM_PINS-1:0] r_running;
    logic [LW-1:0]       r_high  [NUM_PINS];
    logic [LW-1:0]       r_low   [NUM_PINS];
    logic [LW-1:0]       r_cdown [NUM_PINS];
    logic                r_lvl   [NUM_PINS];

    // work registers
    logic [IDX_W-1:0]              r_idx;
    logic [NUM_PINS-1:0]           r_setm;
    logic [NUM_PINS-1:0]           r_clrm;
    logic [LW-1:0]                 r_nl;
    logic [mpwm_pkg::STAT_W-1:0]   r_status;
    logic                          r_bad;
    logic [LW-1:0]                 r_pm;
    logic [LW-1:0]                 r_thc;
    logic [LW-1:0]                 r_th;
    logic [LW-1:0]                 r_tl;
    logic                          r_th_diff;
    logic                          r_s1_valid;
    logic [LW-1:0]                 r_s1_c;

    // result register
    logic                          r_out_valid;
    logic [NUM_PINS-1:0]           r_out_set;
    logic [NUM_PINS-1:0]           r_out_clr;
    logic [LW-1:0]                 r_out_next;
    logic                          r_out_reload;
    logic                          r_out_en;
    logic [mpwm_pkg::STAT_W-1:0]   r_out_status;

    logic [NUM_PINS-1:0] w_pin_hot;
    logic [NUM_PINS-1:0] w_idx_hot;
    logic [NUM_PINS-1:0] w_addr_hot;
    logic [IDX_W-1:0]    w_addr;
    logic                w_pin_ok;
    logic                w_act;
    logic [LW-1:0]       w_h;
    logic [LW-1:0]       w_l;
    logic [LW-1:0]       w_cd;
    logic                w_lv;
    logic [LW+1:0]       w_diff;
    logic                w_le;
    logic                w_elig;
    logic [LW-1:0]       w_newc;
    logic                w_changed;
    logic [LW-1:0]       w_min_ext;

    // one-hot selects for the addressed pin and the walk index
    always_comb begin
        for (int i = 0; i < NUM_PINS; i++) begin
            w_pin_hot[i] = (r_pin == PW'(i));
            w_idx_hot[i] = (r_idx == IDX_W'(i));
        end
    end

    assign w_pin_ok   = ({1'b0, r_pin} < NUM_PINS_V);
    assign w_addr     = i_ctl.tick_step ? r_idx : r_pin[IDX_W-1:0];
    assign w_addr_hot = i_ctl.tick_step ? w_idx_hot : w_pin_hot;
    assign w_min_ext  = {{(LW - MW){1'b0}}, r_min_load};

    // entry read, high and low loads of inactive entries read as cleared
    assign w_act = |(r_active & w_addr_hot);
    assign w_h   = w_act ? r_high[w_addr] : '0;
    assign w_l   = w_act ? r_low[w_addr] : '0;
    assign w_cd  = r_cdown[w_addr];
    assign w_lv  = r_lvl[w_addr];

    // tick stage one: subtract elapsed load and decide toggle
    assign w_diff = {2'b00, w_cd} - {2'b00, r_elapsed};
    assign w_le   = $signed(w_diff) <= $signed({3'b000, r_min_load});
    assign w_elig = w_act && (w_h != '0) && (w_l != '0);
    assign w_newc = w_le ? (w_lv ? w_l : w_h) : w_diff[LW-1:0];

    assign w_changed = r_th_diff || (r_tl != w_l);

    // status towards the controller
    assign o_stat.is_tick   = (r_cmd == mpwm_pkg::CMD_TICK);
    assign o_stat.is_set    = (r_cmd == mpwm_pkg::CMD_SET);
    assign o_stat.is_remove = (r_cmd == mpwm_pkg::CMD_REMOVE);
    assign o_stat.idx_last  = (r_idx == LAST_IDX);
    assign o_stat.out_free  = !r_out_valid || i_m_tready;

    // captured word, set arithmetic and tick stage one register
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd     <= i_command;
            r_pin     <= i_data[PW-1:0];
            r_period  <= i_data[PW+LW-1:PW];
            r_req     <= i_data[PW+2*LW-1:PW+LW];
            r_level   <= i_data[PW+2*LW];
            r_elapsed <= i_data[PW+3*LW:PW+2*LW+1];
        end
        if (i_ctl.set_check) begin
            r_bad <= !w_pin_ok || (r_period > r_max_load) ||
                     ({1'b0, r_period} < {1'b0, r_min_load, 1'b0});
            r_pm  <= r_period - w_min_ext;
            r_thc <= (r_req < w_min_ext) ? w_min_ext : r_req;
        end
        if (i_ctl.set_clamp) begin
            r_th <= (r_thc > r_pm) ? r_pm : r_thc;
        end
        if (i_ctl.set_low) begin
            r_tl      <= r_period - r_th;
            r_th_diff <= (r_th != w_h);
        end
        if (i_ctl.tick_step) begin
            r_s1_c <= w_newc;
        end
    end

    // channel payload writes
    always_ff @(posedge i_clk) begin
        if (i_ctl.tick_step && w_elig) begin
            r_cdown[w_addr] <= w_newc;
            if (w_le) begin
                r_lvl[w_addr] <= !w_lv;
            end
        end
        if (i_ctl.set_commit && !r_bad) begin
            r_high[w_addr] <= r_th;
            r_low[w_addr]  <= r_tl;
            if (w_changed && (r_th != '0) && (r_tl != '0)) begin
                r_lvl[w_addr]   <= r_level;
                r_cdown[w_addr] <= r_level ? r_th : r_tl;
            end
        end
    end

    // configuration, control state, masks, minimum search and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_load  <= mpwm_pkg::RST_MIN_LOAD;
            r_max_load  <= mpwm_pkg::RST_MAX_LOAD;
            r_active    <= '0;
            r_running   <= '0;
            r_idx       <= '0;
            r_setm      <= '0;
            r_clrm      <= '0;
            r_nl        <= '0;
            r_status    <= mpwm_pkg::STAT_OK;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == mpwm_pkg::CFG_MIN_LOAD) begin
                    r_min_load <= i_cfg_data[MW-1:0];
                end else if (i_cfg_index == mpwm_pkg::CFG_MAX_LOAD) begin
                    r_max_load <= i_cfg_data;
                end
            end
            r_s1_valid <= i_ctl.tick_step && w_elig;
            if (i_ctl.capture) begin
                r_idx    <= '0;
                r_setm   <= '0;
                r_clrm   <= '0;
                r_nl     <= r_max_load;
                r_status <= mpwm_pkg::STAT_OK;
            end
            // walk one entry a cycle
            if (i_ctl.tick_step) begin
                r_idx <= r_idx + 1'b1;
                if (w_elig && w_le) begin
                    if (w_lv) begin
                        r_clrm <= r_clrm | w_idx_hot;
                    end else begin
                        r_setm <= r_setm | w_idx_hot;
                    end
                end
            end
            // tick stage two: running minimum
            if (r_s1_valid && (r_s1_c < r_nl)) begin
                r_nl <= r_s1_c;
            end
            if (i_ctl.set_commit) begin
                if (r_bad) begin
                    r_status <= mpwm_pkg::STAT_BAD_PERIOD;
                end else begin
                    r_active <= r_active | w_pin_hot;
                    if ((r_th != '0) || (r_tl != '0)) begin
                        r_running <= r_running | w_pin_hot;
                    end else begin
                        r_running <= r_running & ~w_pin_hot;
                    end
                    if (w_changed && (r_tl == '0)) begin
                        r_setm <= w_pin_hot;
                    end else if (w_changed && (r_th == '0)) begin
                        r_clrm <= w_pin_hot;
                    end
                end
            end
            if (i_ctl.remove) begin
                if (!w_pin_ok || !w_act) begin
                    r_status <= mpwm_pkg::STAT_NOT_ACTIVE;
                end else begin
                    r_active  <= r_active & ~w_pin_hot;
                    r_running <= r_running & ~w_pin_hot;
                    r_clrm    <= w_pin_hot;
                end
            end
            // result word
            if (i_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out_set    <= r_setm;
            r_out_clr    <= r_clrm;
            r_out_next   <= o_stat.is_tick ? r_nl : '0;
            r_out_reload <= o_stat.is_tick && (r_nl != r_elapsed);
            r_out_en     <= |r_running;
            r_out_status <= r_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_W - USED){1'b0}}, r_out_status, r_out_en, r_out_reload,
                         r_out_next, r_out_clr, r_out_set};

`ifndef SYNTH
    // a pin is never both raised and lowered in one word
    a_mask_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_set & r_out_clr) == '0))
        else $error("set and clear masks overlap");

    // a rejected command moves no pin
    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != mpwm_pkg::STAT_OK)) |->
        ((r_out_set == '0) && (r_out_clr == '0)))
        else $error("rejected command drives pins");

    // a running channel is always an active one
    a_running_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_running & ~r_active) == '0)
        else $error("running channel not active");

    // the minimum stage only sees entries from the walk
    a_stage_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $past(i_ctl.tick_step))
        else $error("minimum stage loaded outside a tick walk");
`endif

endmodule

// ===== sv/multichannel_pwm_scheduler_unit.sv =====
// top level of the multichannel pwm scheduler: ports, controller and datapath
//
// Usage: one command word enters on the s channel (tvalid/tready), tuser holds
// the command code (tick, set channel, remove channel), tdata the operands.
// Every command returns exactly one result word on the m channel carrying the
// set and clear pin masks, the next timer load, the reload and enable flags
// and a status code. The cfg channel writes min_load (index 0) and max_load
// (index 1); it is always ready. It must be written only while no command is
// open; the block itself does not enforce this. A tick walks the channel
// store, one entry a cycle, through a two-stage subtract/toggle and minimum
// pipeline. One command is in work at a time; the next is taken once the
// previous one has reached the result register. Reset clears all channels to
// inactive and loads min_load 500 and max_load 8000000; no clearing pass is
// needed. When the receiver stalls, the result word holds and a following
// command is accepted and worked, then waits in its last step until the
// result register frees.
module multichannel_pwm_scheduler_unit #(
    parameter int NUM_PINS = mpwm_pkg::DEF_NUM_PINS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // pin, period_ticks, high_request, pin_level, elapsed_ticks, zero pad
    input  logic [mpwm_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // command
    input  logic [mpwm_pkg::CMD_W-1:0]         i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // set_mask, clear_mask, next_timer_load, reload_timer, timer_enable, status, zero pad
    output logic [((2 * NUM_PINS + mpwm_pkg::LOAD_W + 4 + 7) / 8) * 8 - 1:0] o_m_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mpwm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mpwm_pkg::LOAD_W-1:0]        i_cfg_data
);

    localparam int OUT_W = ((2 * NUM_PINS + mpwm_pkg::LOAD_W + 4 + 7) / 8) * 8;

    mpwm_pkg::t_ctl  w_ctl;
    mpwm_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    // sequencer
    mpwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_ctl      (w_ctl)
    );

    // channel store and arithmetic
    mpwm_dpath #(
        .NUM_PINS (NUM_PINS),
        .OUT_W    (OUT_W)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .o_stat      (w_stat),
        .i_command   (i_s_tuser),
        .i_data      (i_s_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule
